[rtl/threshold_priority_queue_macros.svh]
// Assertion macros for the checker file of the threshold priority queue.
`ifndef THRESHOLD_PRIORITY_QUEUE_MACROS_SVH
`define THRESHOLD_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define TPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/tpq_pkg.sv]
`default_nettype none
package tpq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W = 32;

  typedef enum logic [1:0] {
    OP_ENQ_TAIL = 2'd0,
    OP_ENQ_PRIO = 2'd1,
    OP_DEQ      = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAIL,
    CELL_PRIO,
    CELL_POP
  } cell_op_e;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [VAL_W-1:0]  item_value;
  } tpq_cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [VAL_W-1:0]  removed_value;
    logic [4:0]               occupancy;
  } tpq_result_t;

  typedef struct packed {
    cell_op_e                 mode;
    logic signed [VAL_W-1:0]  threshold;
    logic signed [VAL_W-1:0]  item_value;
  } tpq_cell_ctrl_t;

  // Carried from cell to cell toward the tail.
  typedef struct packed {
    logic prefix;   // every cell so far is held and at or above threshold
    logic reached;  // insertion point lies at or before the previous cell
  } tpq_link_t;

endpackage
`default_nettype wire

[rtl/tpq_cell.sv]
`default_nettype none
module tpq_cell (
  input  wire logic                           clk_i,
  input  wire tpq_pkg::tpq_cell_ctrl_t        ctrl_i,
  input  wire logic                           occupied_i,
  input  wire logic                           at_tail_i,
  input  wire logic signed [tpq_pkg::VAL_W-1:0] left_i,
  input  wire logic signed [tpq_pkg::VAL_W-1:0] right_i,
  input  wire tpq_pkg::tpq_link_t             link_i,
  output tpq_pkg::tpq_link_t                  link_o,
  output logic signed [tpq_pkg::VAL_W-1:0]    value_o
);
  import tpq_pkg::*;

  logic signed [VAL_W-1:0] value_q, value_d;
  logic                    hi;
  logic                    insert_here;

  assign hi          = value_q >= ctrl_i.threshold;
  assign insert_here = link_i.prefix & ~(occupied_i & hi);

  assign link_o.prefix  = link_i.prefix & occupied_i & hi;
  assign link_o.reached = link_i.reached | insert_here;

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.mode)
      CELL_HOLD: value_d = value_q;
      CELL_TAIL: if (at_tail_i) value_d = ctrl_i.item_value;
      CELL_PRIO: begin
        if (insert_here) value_d = ctrl_i.item_value;
        else if (link_i.reached) value_d = left_i;
      end
      CELL_POP:  value_d = right_i;
      default:   value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
`default_nettype wire

[rtl/threshold_priority_queue.sv]
`default_nettype none
// Threshold priority queue: a row of DEPTH cells holds the queue, head in
// cell 0. A command is transferred whenever start is high (busy stays low),
// and its result appears on result_o with result_valid_o high for exactly
// one cycle, the cycle after the transfer.
// The receiver cannot stall, so capture each result as it is strobed. Cells
// compare their own entries with the threshold in parallel; the insertion
// point of a priority enqueue ripples down the row of cells in that same
// cycle, which sets the clock period of this design. The threshold register
// resets to 60 and is written through cfg_valid_i/cfg_data_i at any time the
// block is idle; cfg_ready_o is always high.
module threshold_priority_queue (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire tpq_pkg::tpq_cmd_t              cmd_i,
  output logic                                result_valid_o,
  output tpq_pkg::tpq_result_t                result_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic signed [tpq_pkg::VAL_W-1:0] cfg_data_i
);
  import tpq_pkg::*;

  localparam logic signed [VAL_W-1:0] THR_RESET = VAL_W'(60);

  logic signed [VAL_W-1:0] thr_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    valid_q;
  tpq_result_t             result_q, result_d;

  logic                    accept;
  logic                    full;
  logic                    empty;
  tpq_cell_ctrl_t          ctrl;

  logic signed [VAL_W-1:0] cell_val [DEPTH];
  logic signed [VAL_W-1:0] left_val [DEPTH];
  logic signed [VAL_W-1:0] right_val [DEPTH];
  tpq_link_t               link [DEPTH+1];

  // Never back-pressured.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  // Decode the command into one cell mode for the whole row.
  always_comb begin
    ctrl.mode       = CELL_HOLD;
    ctrl.threshold  = thr_q;
    ctrl.item_value = cmd_i.item_value;
    count_d         = count_q;
    result_d.status        = STAT_DONE;
    result_d.removed_value = '0;
    if (accept) begin
      unique case (cmd_i.operation) inside
        OP_ENQ_TAIL, OP_ENQ_PRIO: begin
          if (full) begin
            // Drop the item; the queue stays as it is.
            result_d.status = STAT_FULL;
          end else begin
            count_d = count_q + CNT_W'(1);
            if (cmd_i.operation == OP_ENQ_PRIO && cmd_i.item_value >= thr_q) begin
              ctrl.mode = CELL_PRIO;
            end else begin
              ctrl.mode = CELL_TAIL;
            end
          end
        end
        OP_DEQ: begin
          if (empty) begin
            result_d.status = STAT_EMPTY;
          end else begin
            count_d                = count_q - CNT_W'(1);
            ctrl.mode              = CELL_POP;
            result_d.removed_value = cell_val[0];
          end
        end
        default: begin
          // Undefined code: report done, leave the queue untouched.
        end
      endcase
    end
    result_d.occupancy = 5'(count_d);
  end

  // Head of the chain: nothing before cell 0, so the prefix run starts true.
  assign link[0].prefix  = 1'b1;
  assign link[0].reached = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_val[i] = cmd_i.item_value;
    end else begin : g_body
      assign left_val[i] = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_val[i] = cell_val[i];
    end else begin : g_mid
      assign right_val[i] = cell_val[i+1];
    end

    tpq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (count_q > CNT_W'(i)),
      .at_tail_i  (count_q == CNT_W'(i)),
      .left_i     (left_val[i]),
      .right_i    (right_val[i]),
      .link_i     (link[i]),
      .link_o     (link[i+1]),
      .value_o    (cell_val[i])
    );
  end

  // Hold the threshold and count; advance the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THR_RESET;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) thr_q <= cfg_data_i;
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) result_q <= result_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule
`default_nettype wire

[rtl/tpq_checker.sv]
`default_nettype none
`include "threshold_priority_queue_macros.svh"
module tpq_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             start,
  input wire logic                             busy,
  input wire tpq_pkg::tpq_cmd_t                cmd_i,
  input wire logic                             result_valid_o,
  input wire tpq_pkg::tpq_result_t             result_o
);
  import tpq_pkg::*;

  logic       cmd_xfer;
  logic       res_empty;
  logic       res_full;
  logic       res_no_deq;
  logic       empty_ok;
  logic       full_ok;
  logic       no_value;
  logic [1:0] last_op_q;

  assign cmd_xfer   = start && !busy;
  assign res_empty  = result_valid_o && (result_o.status == STAT_EMPTY);
  assign res_full   = result_valid_o && (result_o.status == STAT_FULL);
  assign res_no_deq = result_valid_o && (last_op_q != OP_DEQ);
  assign no_value   = (result_o.removed_value == '0);
  assign empty_ok   = no_value && (result_o.occupancy == '0);
  assign full_ok    = no_value && (result_o.occupancy == 5'(DEPTH));

  // Hold the code of the command seen at the previous edge.
  always_ff @(posedge clk_i) begin
    last_op_q <= cmd_i.operation;
  end

  `TPQ_ASSERT_NEXT(a_result_follows_cmd, clk_i, rst_ni, cmd_xfer, result_valid_o)
  `TPQ_ASSERT_NOW(a_no_spurious_result, clk_i, rst_ni, result_valid_o, $past(cmd_xfer))
  `TPQ_ASSERT_NOW(a_empty_result, clk_i, rst_ni, res_empty, empty_ok)
  `TPQ_ASSERT_NOW(a_full_result, clk_i, rst_ni, res_full, full_ok)
  `TPQ_ASSERT_NOW(a_only_deq_removes, clk_i, rst_ni, res_no_deq, no_value)

endmodule

bind threshold_priority_queue tpq_checker u_tpq_checker (.*);
`default_nettype wire

[tb/sv/threshold_priority_queue_checker.sv]
`timescale 1ns / 1ps
module threshold_priority_queue_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  tpq_pkg::tpq_cmd_t                   cmd_i,
  input  logic                                result_valid_i,
  input  tpq_pkg::tpq_result_t                result_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic signed [tpq_pkg::VAL_W-1:0]    cfg_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  full_drops_o,
  output int                                  empty_pops_o
);
  import tpq_pkg::*;

  localparam logic signed [VAL_W-1:0] RESET_THRESHOLD = 32'sd60;

  // Shadow copy of the queue, head in slot 0.
  logic signed [VAL_W-1:0] slots [DEPTH];
  int unsigned             held = 0;
  logic signed [VAL_W-1:0] threshold_copy = RESET_THRESHOLD;

  tpq_result_t pending_results [$];
  int          mismatches = 0;
  int          full_drops = 0;
  int          empty_pops = 0;

  assign fail_count_o = mismatches;
  assign full_drops_o = full_drops;
  assign empty_pops_o = empty_pops;

  // Apply one command to the shadow queue and return the result it causes.
  function automatic tpq_result_t apply_queue_op(input tpq_cmd_t cmd);
    tpq_result_t             res;
    logic signed [VAL_W-1:0] value;
    int unsigned             slot;
    value             = cmd.item_value;
    res.status        = STAT_DONE;
    res.removed_value = '0;
    case (cmd.operation)
      OP_ENQ_TAIL, OP_ENQ_PRIO: begin
        if (held >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          slot = held;
          if (cmd.operation == OP_ENQ_PRIO && $signed(value) >= $signed(threshold_copy)) begin
            // skip the leading run of priority entries
            slot = 0;
            while (slot < held && $signed(slots[slot]) >= $signed(threshold_copy)) slot++;
          end
          for (int i = held; i > slot; i--) slots[i] = slots[i-1];
          slots[slot] = value;
          held++;
        end
      end
      OP_DEQ: begin
        if (held == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.removed_value = slots[0];
          for (int i = 1; i < held; i++) slots[i-1] = slots[i];
          held--;
        end
      end
      default: ;
    endcase
    res.occupancy = 5'(held);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tpq_result_t want;
    if (!rst_ni) begin
      held           = 0;
      threshold_copy = RESET_THRESHOLD;
      for (int i = 0; i < DEPTH; i++) slots[i] = '0;
      pending_results.delete();
      pending_o <= 0;
    end else begin
      if (result_valid_i === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no command waiting for it");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (result_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_i.status);
            mismatches++;
          end
          if (result_i.removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, got %0d",
                   $signed(want.removed_value), $signed(result_i.removed_value));
            mismatches++;
          end
          if (result_i.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, result_i.occupancy);
            mismatches++;
          end
          if (want.status == STAT_FULL) full_drops++;
          if (want.status == STAT_EMPTY) empty_pops++;
        end
      end
      // A command at this edge still sees the old threshold.
      if (start_i && !busy_i) pending_results.push_back(apply_queue_op(cmd_i));
      if (cfg_valid_i && cfg_ready_i) threshold_copy = cfg_data_i;
      pending_o <= pending_results.size();
    end
  end

endmodule

[tb/sv/threshold_priority_queue_test.sv]
`timescale 1ns / 1ps
module threshold_priority_queue_test;
  import tpq_pkg::*;

  // Operation code 3 has no name in the package; the block must ignore it.
  localparam logic [1:0]              OP_RESERVED    = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN        = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX        = 32'sh7fff_ffff;
  localparam int                      PHASES         = 7;
  localparam int                      PHASE_ITEMS    = 130;
  localparam int                      SETTLE_CYCLES  = 4;
  localparam int                      WATCHDOG_LIMIT = 500;

  logic                    clk_i     = 1'b0;
  logic                    rst_ni    = 1'b0;
  logic                    start     = 1'b0;
  logic                    busy;
  tpq_cmd_t                cmd       = '0;
  logic                    result_valid;
  tpq_result_t             result;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic signed [VAL_W-1:0] cfg_data  = '0;

  int                      fail_count;
  int                      pending;
  int                      full_drops;
  int                      empty_pops;
  int                      issued    = 0;
  int                      settings  = 1;
  int                      idle_cycles = 0;
  // Track the threshold so values can be aimed at its boundary.
  logic signed [VAL_W-1:0] cur_threshold = 32'sd60;

  // 20 ns clock: high half, then low half.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  threshold_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd),
    .result_valid_o (result_valid),
    .result_o       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  threshold_priority_queue_checker queue_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd),
    .result_valid_i (result_valid),
    .result_i       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .full_drops_o   (full_drops),
    .empty_pops_o   (empty_pops)
  );

  // Watchdog: count cycles in which no transfer of any kind happens and
  // abort once the count shows the block has stopped making progress.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid === 1'b1 || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a transfer", idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one command and hold it until the transfer happens. The caller
  // decides whether start stays high for a following command.
  task automatic issue_op(input logic [1:0] op, input logic signed [VAL_W-1:0] value);
    start <= 1'b1;
    cmd   <= '{operation: op, item_value: value};
    do @(posedge clk_i); while (busy);
    issued++;
  endtask

  // Start must already be low. Wait until every expected result has been
  // checked, then let the pipeline settle.
  task automatic wait_all_results();
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the threshold register; only called while the block is idle.
  task automatic write_threshold(input logic signed [VAL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    cur_threshold  = value;
    settings++;
  endtask

  // Mix values on both sides of the threshold, right at it, the field
  // extremes and fully random patterns.
  function automatic logic signed [VAL_W-1:0] pick_value(input logic signed [VAL_W-1:0] thr);
    case ($urandom_range(0, 5))
      0: return thr;
      1: return thr + $urandom_range(0, 6) - 32'd3;
      2: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return -32'sd1;
        endcase
      end
      3: return $urandom;
      default: return VAL_W'($urandom_range(0, 400) - 200);
    endcase
  endfunction

  // Draw an operation: a few reserved codes, then enqueue or dequeue
  // according to the phase bias.
  function automatic logic [1:0] pick_op(input int enq_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return OP_RESERVED;
    if (roll < enq_pct) return $urandom_range(0, 1) ? OP_ENQ_PRIO : OP_ENQ_TAIL;
    return OP_DEQ;
  endfunction

  initial begin
    int                      sent;
    int                      burst;
    int                      gap;
    int                      enq_pct;
    bit                      quiet;
    logic signed [VAL_W-1:0] thr;

    // Hold reset, then release it on a rising edge.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset threshold of 60.
    issue_op(OP_DEQ, $urandom);            // dequeue from an empty queue
    issue_op(OP_RESERVED, $urandom);       // reserved code on an empty queue
    issue_op(OP_ENQ_TAIL, VAL_MIN);
    issue_op(OP_ENQ_TAIL, VAL_MAX);
    issue_op(OP_ENQ_TAIL, '0);
    issue_op(OP_ENQ_TAIL, -32'sd1);
    issue_op(OP_ENQ_PRIO, 32'sd60);        // head below threshold: goes to head
    issue_op(OP_ENQ_PRIO, 32'sd59);        // below threshold: goes to tail
    issue_op(OP_ENQ_PRIO, VAL_MAX);        // lands after the leading priority run
    issue_op(OP_ENQ_PRIO, VAL_MIN);
    issue_op(OP_RESERVED, $urandom);       // reserved code on a non-empty queue
    // Fill up to the last slot.
    repeat (DEPTH - 8) issue_op($urandom_range(0, 1) ? OP_ENQ_PRIO : OP_ENQ_TAIL,
                                pick_value(cur_threshold));
    issue_op(OP_ENQ_TAIL, $urandom);       // full: drop
    issue_op(OP_ENQ_PRIO, 32'sd60);        // full: drop
    issue_op(OP_DEQ, $urandom);
    issue_op(OP_DEQ, $urandom);
    start <= 1'b0;
    wait_all_results();

    // Random phases, each under its own threshold; the extremes are among them.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: thr = $urandom;
        1: thr = VAL_MIN;
        2: thr = VAL_MAX;
        3: thr = '0;
        4: thr = -32'sd1;
        5: thr = 32'sd60;
        default: thr = VAL_W'($urandom_range(0, 200) - 100);
      endcase
      write_threshold(thr);
      // Alternate fill-heavy and drain-heavy phases so the queue swings
      // between full and empty.
      enq_pct = (phase % 2 == 0) ? 70 : 38;
      quiet   = (phase == 4);
      sent    = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          issue_op(pick_op(enq_pct), pick_value(cur_threshold));
          sent++;
        end
        if ($urandom_range(0, 19) == 0) begin
          // pause the sender until the queue has answered everything
          start <= 1'b0;
          wait_all_results();
        end else if (!quiet) begin
          gap = $urandom_range(0, 8);
          if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
      end
      start <= 1'b0;
      wait_all_results();
    end

    $display("covered %0d commands under %0d threshold settings", issued, settings);
    $display("queue-full drops checked: %0d, empty dequeues checked: %0d",
             full_drops, empty_pops);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
